FILE: hdl/lli_pkg.sv
package lli_pkg;

  // Breakpoint table sizing
  localparam int BREAKPOINTS = 13;
  localparam int TABLE_SLOTS = 32;
  localparam int LAST_IDX    = (BREAKPOINTS < 2) ? 1 :
                               (BREAKPOINTS > TABLE_SLOTS) ? TABLE_SLOTS - 1 :
                               BREAKPOINTS - 1;
  localparam int SEG_W       = $clog2(TABLE_SLOTS);

  // Field and datapath widths
  localparam int F_W      = 33;
  localparam int VAL_W    = 5;
  localparam int DIFF_W   = F_W + 2;
  localparam int DV_W     = VAL_W + 1;
  localparam int PROD_W   = DIFF_W + DV_W;
  localparam int N_W      = PROD_W + 1;
  localparam int M_W      = N_W + 2;
  localparam int DIV_STEPS = VAL_W + 1;

  localparam logic [VAL_W-1:0] VALUE_MAX = VAL_W'(31);

  typedef logic [F_W-1:0]   freq_tab_t [TABLE_SLOTS];
  typedef logic [VAL_W-1:0] val_tab_t  [TABLE_SLOTS];

  localparam freq_tab_t BP_FREQ = '{
    33'd450000000,  33'd500000000,  33'd1000000000, 33'd1500000000,
    33'd2000000000, 33'd2500000000, 33'd3000000000, 33'd3550000000,
    33'd4000000000, 33'd4500000000, 33'd5000000000, 33'd5500000000,
    33'd6000000000, 33'd0, 33'd0, 33'd0,
    33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0,
    33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0
  };

  localparam val_tab_t POWER_TAB = '{
    5'd18, 5'd18, 5'd17, 5'd17, 5'd17, 5'd16, 5'd12, 5'd11,
    5'd11, 5'd11, 5'd10, 5'd13, 5'd18, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  localparam val_tab_t ATTEN_RX_TAB = '{
    5'd19, 5'd19, 5'd21, 5'd21, 5'd20, 5'd20, 5'd22, 5'd21,
    5'd20, 5'd22, 5'd22, 5'd24, 5'd26, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  localparam val_tab_t ATTEN_TX_TAB = '{
    5'd19, 5'd19, 5'd21, 5'd21, 5'd20, 5'd20, 5'd22, 5'd21,
    5'd22, 5'd24, 5'd24, 5'd26, 5'd28, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  // Edges from the one that accepts a transaction to the one that takes its result
  localparam int LATENCY = 4 + DIV_STEPS + 1;

endpackage

FILE: hdl/lo_level_interpolator_top.sv
// Oscillator level interpolator.
//
// A request transaction is taken on the rising edge where start is high and
// busy is low; frequency_hz and direction are sampled at that edge. busy is
// only raised while rst is held, so a new request may be issued every cycle.
// Each request produces exactly one result: strobe rises once the request
// has passed every pipeline register listed below and is high for one cycle
// per result with attenuator_setting and synth_power valid alongside it.
// Throughput is one transaction per cycle while rst is low.
//
// The work runs through a fixed pipeline: segment search, segment lookup and
// offset, the four products, the numerator sum, six restoring
// compare-and-subtract steps (one quotient bit each, the first one spotting
// saturation) and a final output register.
//
// The receiver cannot stall, so results are simply presented and move on.
// Reset is synchronous; it clears every valid bit, so nothing in flight is
// delivered afterwards, and no request is taken while rst is high.
module lo_level_interpolator_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [lli_pkg::F_W-1:0]  frequency_hz,
  input  logic                     direction,
  output logic                     strobe,
  output logic [lli_pkg::VAL_W-1:0] attenuator_setting,
  output logic [lli_pkg::VAL_W-1:0] synth_power
);
  import lli_pkg::*;

  typedef struct packed {
    logic [M_W-1:0]       rem_a;
    logic [M_W-1:0]       rem_p;
    logic [M_W-1:0]       dvsr;
    logic                 neg_a;
    logic                 neg_p;
    logic                 degen;
    logic [VAL_W-1:0]     lo_a;
    logic [VAL_W-1:0]     lo_p;
    logic [DIV_STEPS-1:0] q_a;
    logic [DIV_STEPS-1:0] q_p;
  } div_stage_t;

  logic accept;

  // Stage 1: clamp and segment search
  logic [F_W-1:0]   f_clamp;
  logic [SEG_W-1:0] seg_next;
  logic             v1;
  logic [F_W-1:0]   f1;
  logic [SEG_W-1:0] seg1;
  logic             dir1;

  // Stage 2: segment lookup and offsets
  logic [SEG_W-1:0]        seg_hi;
  logic [VAL_W-1:0]        lo_a_sel;
  logic [VAL_W-1:0]        hi_a_sel;
  logic                    v2;
  logic signed [DIFF_W-1:0] diff2;
  logic signed [DIFF_W-1:0] d2;
  logic signed [DV_W-1:0]   dv_a2;
  logic signed [DV_W-1:0]   dv_p2;
  logic signed [DV_W-1:0]   lo_a2;
  logic signed [DV_W-1:0]   lo_p2;

  // Stage 3: products
  logic                     v3;
  logic signed [PROD_W-1:0] prod_a3;
  logic signed [PROD_W-1:0] prod_p3;
  logic signed [PROD_W-1:0] base_a3;
  logic signed [PROD_W-1:0] base_p3;
  logic signed [DIFF_W-1:0] d3;
  logic                     degen3;
  logic [VAL_W-1:0]         lo_a3;
  logic [VAL_W-1:0]         lo_p3;

  // Stage 4 feeds the divider
  logic signed [N_W-1:0] n_a;
  logic signed [N_W-1:0] n_p;
  div_stage_t            dstage_next;

  logic       dvalid [DIV_STEPS+1];
  div_stage_t dstage [DIV_STEPS+1];

  // Final formatting
  div_stage_t       dlast;
  logic [VAL_W-1:0] res_a;
  logic [VAL_W-1:0] res_p;

  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage 1
  // The lowest segment whose upper breakpoint is not below the frequency.
  always_comb begin
    f_clamp  = (frequency_hz > BP_FREQ[LAST_IDX]) ? BP_FREQ[LAST_IDX] : frequency_hz;
    seg_next = SEG_W'(LAST_IDX - 1);
    for (int i = LAST_IDX - 1; i >= 1; i--) begin
      if (f_clamp <= BP_FREQ[i]) begin
        seg_next = SEG_W'(i - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    f1   <= f_clamp;
    seg1 <= seg_next;
    dir1 <= direction;
  end

  // ---------------------------------------------------------------- stage 2
  assign seg_hi   = SEG_W'(seg1 + 1'b1);
  assign lo_a_sel = dir1 ? ATTEN_RX_TAB[seg1]   : ATTEN_TX_TAB[seg1];
  assign hi_a_sel = dir1 ? ATTEN_RX_TAB[seg_hi] : ATTEN_TX_TAB[seg_hi];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    diff2 <= $signed({2'b00, f1}) - $signed({2'b00, BP_FREQ[seg1]});
    d2    <= $signed({2'b00, BP_FREQ[seg_hi]}) - $signed({2'b00, BP_FREQ[seg1]});
    dv_a2 <= $signed({1'b0, hi_a_sel}) - $signed({1'b0, lo_a_sel});
    dv_p2 <= $signed({1'b0, POWER_TAB[seg_hi]}) - $signed({1'b0, POWER_TAB[seg1]});
    lo_a2 <= $signed({1'b0, lo_a_sel});
    lo_p2 <= $signed({1'b0, POWER_TAB[seg1]});
  end

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    prod_a3 <= diff2 * dv_a2;
    prod_p3 <= diff2 * dv_p2;
    base_a3 <= lo_a2 * d2;
    base_p3 <= lo_p2 * d2;
    d3      <= d2;
    degen3  <= (d2 <= 0);
    lo_a3   <= lo_a2[VAL_W-1:0];
    lo_p3   <= lo_p2[VAL_W-1:0];
  end

  // ---------------------------------------------------------------- stage 4
  // Rounding half away from zero on a non-negative numerator is
  // floor((2n + d) / 2d); a negative numerator saturates to zero unless the segment is degenerate.
  always_comb begin
    n_a = N_W'(base_a3) + N_W'(prod_a3);
    n_p = N_W'(base_p3) + N_W'(prod_p3);
    dstage_next.rem_a = (M_W'($unsigned(n_a)) << 1) + M_W'($unsigned(d3));
    dstage_next.rem_p = (M_W'($unsigned(n_p)) << 1) + M_W'($unsigned(d3));
    dstage_next.dvsr  = degen3 ? '0 : M_W'($unsigned(d3));
    dstage_next.neg_a = n_a[N_W-1];
    dstage_next.neg_p = n_p[N_W-1];
    dstage_next.degen = degen3;
    dstage_next.lo_a  = lo_a3;
    dstage_next.lo_p  = lo_p3;
    dstage_next.q_a   = '0;
    dstage_next.q_p   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid[0] <= 1'b0;
    end else begin
      dvalid[0] <= v3;
    end
    dstage[0] <= dstage_next;
  end

  // ------------------------------------------------------- divider stages
  // Step j settles quotient bit DIV_STEPS-1-j against 2d shifted to match.
  // The top bit set means the quotient is 32 or more and the value saturates.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [M_W-1:0] trial;
    div_stage_t     step_next;

    always_comb begin
      trial     = dstage[j].dvsr << (K + 1);
      step_next = dstage[j];
      if (dstage[j].rem_a >= trial) begin
        step_next.rem_a  = dstage[j].rem_a - trial;
        step_next.q_a[K] = 1'b1;
      end
      if (dstage[j].rem_p >= trial) begin
        step_next.rem_p  = dstage[j].rem_p - trial;
        step_next.q_p[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvalid[j+1] <= 1'b0;
      end else begin
        dvalid[j+1] <= dvalid[j];
      end
      dstage[j+1] <= step_next;
    end
  end

  // ---------------------------------------------------------- output stage
  assign dlast = dstage[DIV_STEPS];

  always_comb begin
    if (dlast.degen) begin
      res_a = dlast.lo_a;
    end else if (dlast.neg_a) begin
      res_a = '0;
    end else if (dlast.q_a[DIV_STEPS-1]) begin
      res_a = VALUE_MAX;
    end else begin
      res_a = dlast.q_a[VAL_W-1:0];
    end
    if (dlast.degen) begin
      res_p = dlast.lo_p;
    end else if (dlast.neg_p) begin
      res_p = '0;
    end else if (dlast.q_p[DIV_STEPS-1]) begin
      res_p = VALUE_MAX;
    end else begin
      res_p = dlast.q_p[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dvalid[DIV_STEPS];
    end
    attenuator_setting <= res_a;
    synth_power        <= res_p;
  end

  // ------------------------------------------------------------ assertions
  // Every accepted request comes out after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY strobe)
    else $error("accepted request produced no result strobe");

  // No result appears without a request taken the pipeline depth earlier.
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, LATENCY))
    else $error("result strobe does not line up with an accepted request");

  // The segment search never runs past the last real segment.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ($past(seg1) <= SEG_W'(LAST_IDX - 1)))
    else $error("segment index beyond the table");

  // Unless degenerate, negative or saturated, the attenuator divider leaves a remainder below its divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (dvalid[DIV_STEPS] && !dlast.degen && !dlast.neg_a && !dlast.q_a[DIV_STEPS-1])
      |-> (dlast.rem_a < (dlast.dvsr << 1)))
    else $error("attenuator remainder out of range after the last divider step");

endmodule
